// File: hdl/qle_pkg.sv
package qle_pkg;

  // Default table geometry
  localparam int GRID_CELLS_DEF  = 64;
  localparam int WAIT_LEVELS_DEF = 4;
  localparam int NUM_ACTIONS_DEF = 4;

  // Configuration register indexes and reset values
  localparam logic [1:0] REG_EXPLORE_RATE    = 2'd0;
  localparam logic [1:0] REG_LEARNING_RATE   = 2'd1;
  localparam logic [1:0] REG_DISCOUNT_FACTOR = 2'd2;

  localparam logic [15:0] EXPLORE_RATE_RST    = 16'd13107;
  localparam logic [15:0] LEARNING_RATE_RST   = 16'd13107;
  localparam logic [15:0] DISCOUNT_FACTOR_RST = 16'd62259;

  // Command codes
  localparam logic CMD_SELECT = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_READ,
    ST_LAST,
    ST_FINISH,
    ST_CALC
  } state_t;

  // Result of the update datapath
  typedef struct packed {
    logic               valid;
    logic               sat;
    logic signed [31:0] value;
  } upd_res_t;

  // Shift one bit into a remainder modulo m (m at most 1024)
  function automatic logic [10:0] mod_shift_in(input logic [10:0] r, input logic b,
                                               input logic [10:0] m);
    logic [10:0] t;
    t = {r[9:0], b};
    if (t >= m) begin
      t = t - m;
    end
    return t;
  endfunction

  // Reduce a 6-bit value modulo m, restoring one bit a step
  function automatic logic [10:0] mod_bits6(input logic [10:0] r, input logic [5:0] v,
                                            input logic [10:0] m);
    logic [10:0] acc;
    acc = r;
    for (int i = 5; i >= 0; i--) begin
      acc = mod_shift_in(acc, v[i], m);
    end
    return acc;
  endfunction

  // Continue a remainder modulo m over eight more bits
  function automatic logic [10:0] mod_bits8(input logic [10:0] r, input logic [7:0] v,
                                            input logic [10:0] m);
    logic [10:0] acc;
    acc = r;
    for (int i = 7; i >= 0; i--) begin
      acc = mod_shift_in(acc, v[i], m);
    end
    return acc;
  endfunction

endpackage

// File: hdl/qle_ram.sv
module qle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/qle_update.sv
module qle_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] reward,
  input  logic signed [31:0] best,
  input  logic signed [31:0] q_old,
  input  logic [15:0]        learning_rate,
  input  logic [15:0]        discount_factor,
  output qle_pkg::upd_res_t  res
);
  import qle_pkg::*;

  logic               vld1;
  logic               vld2;
  logic               vld3;
  logic               res_vld;
  logic               res_sat;
  logic signed [31:0] res_val;
  logic signed [48:0] prod_g;
  logic signed [31:0] rew1;
  logic signed [31:0] q1;
  logic signed [33:0] target2;
  logic signed [49:0] pa2;
  logic signed [49:0] pa3;
  logic signed [50:0] pb3;
  logic signed [49:0] tsum;
  logic signed [51:0] msum;
  logic [16:0]        keep;
  logic [35:0]        shifted;
  logic               ovf_pos;
  logic               ovf_neg;

  // Advance the stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      vld1    <= start;
      vld2    <= vld1;
      vld3    <= vld2;
      res_vld <= vld3;
    end
  end

  // Target: round(reward + gamma * best_next)
  assign tsum = $signed({{2{rew1[31]}}, rew1, 16'd0}) + $signed({prod_g[48], prod_g})
              + 50'sd32768;

  // Weight kept on the old value
  assign keep = 17'd65536 - {1'b0, learning_rate};

  // Blend, round and clip
  assign msum = $signed({{2{pa3[49]}}, pa3}) + $signed({pb3[50], pb3}) + 52'sd32768;
  assign shifted = msum[51:16];
  assign ovf_pos = !shifted[35] && (|shifted[34:31]);
  assign ovf_neg = shifted[35] && !(&shifted[34:31]);

  // Stage registers
  always_ff @(posedge clk) begin
    prod_g  <= $signed({1'b0, discount_factor}) * best;
    rew1    <= reward;
    q1      <= q_old;
    target2 <= tsum[49:16];
    pa2     <= $signed({1'b0, keep}) * q1;
    pb3     <= $signed({1'b0, learning_rate}) * target2;
    pa3     <= pa2;
    res_sat <= ovf_pos || ovf_neg;
    if (ovf_pos) begin
      res_val <= 32'sh7FFFFFFF;
    end else if (ovf_neg) begin
      res_val <= $signed(32'h80000000);
    end else begin
      res_val <= shifted[31:0];
    end
  end

  // Pack the result
  assign res = '{valid: res_vld, sat: res_sat, value: res_val};

endmodule

// File: hdl/tabular_q_learning_engine.sv
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------------------
// request   | start, accepted when !busy    | command, cells, wait levels, action, reward,
//           |                               | random_bits
// result    | done, one cycle, no back-off  | chosen_action, explored, q_value, saturated
// config    | write_enable, taken at once   | write_index, write_data
//
// After reset the Q table is cleared one entry a cycle, and busy stays high
// until the clear sweep has written every entry.
// A select request strobes done once the single table read port has scanned the
// row one action a cycle, and an update adds the four-stage multiply pipeline
// before its write-back and its strobe. A new request is taken in the cycle
// done is shown. Results cannot be stalled.
module tabular_q_learning_engine #(
  parameter int GRID_CELLS  = qle_pkg::GRID_CELLS_DEF,
  parameter int WAIT_LEVELS = qle_pkg::WAIT_LEVELS_DEF,
  parameter int NUM_ACTIONS = qle_pkg::NUM_ACTIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [5:0]         agent_cell,
  input  logic [5:0]         other_cell,
  input  logic [1:0]         wait_level,
  input  logic [1:0]         taken_action,
  input  logic signed [31:0] reward,
  input  logic [5:0]         next_agent_cell,
  input  logic [5:0]         next_other_cell,
  input  logic [1:0]         next_wait_level,
  input  logic [31:0]        random_bits,
  input  logic               write_enable,
  input  logic [1:0]         write_index,
  input  logic [15:0]        write_data,
  output logic               done,
  output logic [1:0]         chosen_action,
  output logic               explored,
  output logic signed [31:0] q_value,
  output logic               saturated
);
  import qle_pkg::*;

  localparam int CELL_W = $clog2(GRID_CELLS);
  localparam int WAIT_W = (WAIT_LEVELS > 1) ? $clog2(WAIT_LEVELS) : 1;
  localparam int ACT_W  = $clog2(NUM_ACTIONS);
  localparam int KW     = $clog2(NUM_ACTIONS + 1);
  localparam int OW_W   = $clog2(GRID_CELLS * WAIT_LEVELS);
  localparam int ROW_W  = $clog2(GRID_CELLS * GRID_CELLS * WAIT_LEVELS);
  localparam int DEPTH  = GRID_CELLS * GRID_CELLS * WAIT_LEVELS * NUM_ACTIONS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [10:0]       MOD_G     = 11'(GRID_CELLS);
  localparam logic [10:0]       MOD_W     = 11'(WAIT_LEVELS);
  localparam logic [10:0]       MOD_N     = 11'(NUM_ACTIONS);
  localparam logic [KW-1:0]     K_CUR     = KW'(NUM_ACTIONS);
  localparam logic [KW-1:0]     K_LASTROW = KW'(NUM_ACTIONS - 1);
  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);

  state_t state;
  state_t state_next;

  logic [15:0] explore_rate;
  logic [15:0] learning_rate;
  logic [15:0] discount_factor;

  logic               accept;
  logic               cmd_q;
  logic [CELL_W-1:0]  a_q;
  logic [CELL_W-1:0]  o_q;
  logic [WAIT_W-1:0]  w_q;
  logic [CELL_W-1:0]  na_q;
  logic [CELL_W-1:0]  no_q;
  logic [WAIT_W-1:0]  nw_q;
  logic [ACT_W-1:0]   act_q;
  logic signed [31:0] rew_q;
  logic [15:0]        rnd_q;
  logic               explore_q;
  logic [ACT_W-1:0]   rem_q;

  logic [OW_W-1:0]    ow_cur_q;
  logic [OW_W-1:0]    ow_nxt_q;
  logic [ROW_W-1:0]   row_cur_q;
  logic [ROW_W-1:0]   row_nxt_q;
  logic [ROW_W-1:0]   scan_row;
  logic [ADDR_W-1:0]  scan_addr;
  logic [ADDR_W-1:0]  cur_addr_q;
  logic [ADDR_W-1:0]  clr_addr_q;
  logic [KW-1:0]      k_q;
  logic               rd_last;

  logic               data_vld_q;
  logic [KW-1:0]      data_idx_q;
  logic signed [31:0] best_q;
  logic [ACT_W-1:0]   best_act_q;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [31:0]        ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [31:0]        ram_rdata;

  logic               upd_start;
  upd_res_t           upd_res;

  assign accept = start && !busy;

  // Q table storage
  qle_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Update arithmetic
  qle_update u_update (
    .clk             (clk),
    .rst             (rst),
    .start           (upd_start),
    .reward          (rew_q),
    .best            (best_q),
    .q_old           ($signed(ram_rdata)),
    .learning_rate   (learning_rate),
    .discount_factor (discount_factor),
    .res             (upd_res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      explore_rate    <= EXPLORE_RATE_RST;
      learning_rate   <= LEARNING_RATE_RST;
      discount_factor <= DISCOUNT_FACTOR_RST;
    end else if (write_enable) begin
      case (write_index)
        REG_EXPLORE_RATE:    explore_rate    <= write_data;
        REG_LEARNING_RATE:   learning_rate   <= write_data;
        REG_DISCOUNT_FACTOR: discount_factor <= write_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Row scan addressing
  assign scan_row  = (cmd_q == CMD_UPDATE) ? row_nxt_q : row_cur_q;
  assign scan_addr = ADDR_W'(scan_row) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(k_q);
  assign rd_last   = (cmd_q == CMD_UPDATE) ? (k_q == K_CUR) : (k_q == K_LASTROW);
  assign ram_raddr = (k_q == K_CUR) ? cur_addr_q : scan_addr;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_addr_q == CLR_LAST) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_PREP_A;
      ST_PREP_A: state_next = ST_PREP_B;
      ST_PREP_B: state_next = ST_READ;
      ST_READ:   if (rd_last) state_next = ST_LAST;
      ST_LAST:   state_next = (cmd_q == CMD_UPDATE) ? ST_CALC : ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      ST_CALC:   if (upd_res.valid) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy      = (state != ST_IDLE);
    upd_start = (state == ST_LAST) && (cmd_q == CMD_UPDATE);
    ram_we    = 1'b0;
    ram_waddr = cur_addr_q;
    ram_wdata = upd_res.value;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
      end
      ST_CALC: begin
        ram_we = upd_res.valid;
      end
      default: ;
    endcase
  end

  // Clear sweep and read index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr_q <= '0;
      k_q        <= '0;
      data_vld_q <= 1'b0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
      if (state == ST_READ) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
      end
      data_vld_q <= (state == ST_READ);
    end
  end

  // Latch the request, reduced into range
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= command;
      a_q       <= CELL_W'(mod_bits6(11'd0, agent_cell, MOD_G));
      o_q       <= CELL_W'(mod_bits6(11'd0, other_cell, MOD_G));
      w_q       <= WAIT_W'(mod_bits6(11'd0, {4'd0, wait_level}, MOD_W));
      na_q      <= CELL_W'(mod_bits6(11'd0, next_agent_cell, MOD_G));
      no_q      <= CELL_W'(mod_bits6(11'd0, next_other_cell, MOD_G));
      nw_q      <= WAIT_W'(mod_bits6(11'd0, {4'd0, next_wait_level}, MOD_W));
      act_q     <= ACT_W'(mod_bits6(11'd0, {4'd0, taken_action}, MOD_N));
      rew_q     <= reward;
      rnd_q     <= random_bits[15:0];
      explore_q <= (random_bits[31:16] < explore_rate);
    end
  end

  // Build row indexes and the random action in two steps
  always_ff @(posedge clk) begin
    if (state == ST_PREP_A) begin
      ow_cur_q <= OW_W'(o_q) * OW_W'(WAIT_LEVELS) + OW_W'(w_q);
      ow_nxt_q <= OW_W'(no_q) * OW_W'(WAIT_LEVELS) + OW_W'(nw_q);
      rem_q    <= ACT_W'(mod_bits8(11'd0, rnd_q[15:8], MOD_N));
    end
    if (state == ST_PREP_B) begin
      row_cur_q <= ROW_W'(ow_cur_q) * ROW_W'(GRID_CELLS) + ROW_W'(a_q);
      row_nxt_q <= ROW_W'(ow_nxt_q) * ROW_W'(GRID_CELLS) + ROW_W'(na_q);
      rem_q     <= ACT_W'(mod_bits8(11'(rem_q), rnd_q[7:0], MOD_N));
    end
    cur_addr_q <= ADDR_W'(row_cur_q) * ADDR_W'(NUM_ACTIONS) + ADDR_W'(act_q);
    data_idx_q <= k_q;
  end

  // Track the best action of the scanned row, lowest index on ties
  always_ff @(posedge clk) begin
    if (data_vld_q && (data_idx_q != K_CUR)) begin
      if ((data_idx_q == '0) || ($signed(ram_rdata) > best_q)) begin
        best_q     <= $signed(ram_rdata);
        best_act_q <= ACT_W'(data_idx_q);
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_FINISH) || ((state == ST_CALC) && upd_res.valid);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      chosen_action <= explore_q ? 2'(rem_q) : 2'(best_act_q);
      explored      <= explore_q;
      q_value       <= best_q;
      saturated     <= 1'b0;
    end else if ((state == ST_CALC) && upd_res.valid) begin
      chosen_action <= 2'(act_q);
      explored      <= 1'b0;
      q_value       <= upd_res.value;
      saturated     <= upd_res.sat;
    end
  end

  // Table writes come only from the clear sweep or an update write-back
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR) || ((state == ST_CALC) && (cmd_q == CMD_UPDATE)))
    else $error("table write outside clear or update write-back");

  // The strobe follows the finishing state of a request
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_FINISH) || ($past(state) == ST_CALC))
    else $error("result strobe without a finished request");

  // An accepted request starts the preparation steps
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == ST_PREP_A))
    else $error("accepted request did not start");

  // Update results arrive only while waiting for them
  a_upd_wait: assert property (@(posedge clk) disable iff (rst)
    upd_res.valid |-> (state == ST_CALC))
    else $error("update result outside the wait state");

endmodule

// File: tb/tb_tabular_q_learning_engine.sv
`timescale 1ns / 1ps

module tb_tabular_q_learning_engine;
  import qle_pkg::*;

  // Register index that the block does not decode
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int STALL_LIMIT = 300000;
  localparam int POOL_SIZE = 6;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct {
    logic               cmd;
    logic [5:0]         agent;
    logic [5:0]         other;
    logic [1:0]         waitl;
    logic [1:0]         act;
    logic signed [31:0] rew;
    logic [5:0]         nagent;
    logic [5:0]         nother;
    logic [1:0]         nwait;
    logic [31:0]        rnd;
    bit                 flush_first;
  } request_t;

  typedef struct {
    logic [1:0]         action;
    logic               explored;
    logic signed [31:0] value;
    logic               sat;
  } decision_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               command = CMD_SELECT;
  logic [5:0]         agent_cell = '0;
  logic [5:0]         other_cell = '0;
  logic [1:0]         wait_level = '0;
  logic [1:0]         taken_action = '0;
  logic signed [31:0] reward = '0;
  logic [5:0]         next_agent_cell = '0;
  logic [5:0]         next_other_cell = '0;
  logic [1:0]         next_wait_level = '0;
  logic [31:0]        random_bits = '0;
  logic               write_enable = 1'b0;
  logic [1:0]         write_index = '0;
  logic [15:0]        write_data = '0;
  logic               done;
  logic [1:0]         chosen_action;
  logic               explored;
  logic signed [31:0] q_value;
  logic               saturated;

  tabular_q_learning_engine dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .agent_cell      (agent_cell),
    .other_cell      (other_cell),
    .wait_level      (wait_level),
    .taken_action    (taken_action),
    .reward          (reward),
    .next_agent_cell (next_agent_cell),
    .next_other_cell (next_other_cell),
    .next_wait_level (next_wait_level),
    .random_bits     (random_bits),
    .write_enable    (write_enable),
    .write_index     (write_index),
    .write_data      (write_data),
    .done            (done),
    .chosen_action   (chosen_action),
    .explored        (explored),
    .q_value         (q_value),
    .saturated       (saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the Q table and the rate registers
  int          q_shadow [0:65535];
  logic [15:0] epsilon_m = EXPLORE_RATE_RST;
  logic [15:0] alpha_m = LEARNING_RATE_RST;
  logic [15:0] gamma_m = DISCOUNT_FACTOR_RST;

  request_t  requests_q[$];
  decision_t decisions_q[$];
  int        errors = 0;
  bit        steady_tail = 0;

  logic [5:0] pool_agent [POOL_SIZE];
  logic [5:0] pool_other [POOL_SIZE];
  logic [1:0] pool_wait [POOL_SIZE];

  // Append one request to the pending list
  function automatic void add_req(input request_t r);
    requests_q.insert(requests_q.size(), r);
  endfunction

  // Best value of a row and the lowest action that reaches it
  function automatic void row_best(input logic [13:0] row, output logic signed [31:0] bv,
                                   output logic [1:0] ba);
    int k;
    bv = q_shadow[{row, 2'd0}];
    ba = 2'd0;
    for (k = 1; k < 4; k++) begin
      if (q_shadow[{row, k[1:0]}] > bv) begin
        bv = q_shadow[{row, k[1:0]}];
        ba = k[1:0];
      end
    end
  endfunction

  // Select or learn one step, updating the shadow table
  function automatic decision_t choose_or_learn(request_t r);
    decision_t          d;
    logic signed [31:0] best;
    logic [1:0]         best_act;
    logic [15:0]        slot;
    longint             target;
    longint             mix;
    longint             qn;
    d = '{action: 2'd0, explored: 1'b0, value: 32'sd0, sat: 1'b0};
    if (r.cmd == CMD_SELECT) begin
      row_best({r.other, r.waitl, r.agent}, best, best_act);
      d.value = best;
      if (r.rnd[31:16] < epsilon_m) begin
        d.action = r.rnd[1:0];
        d.explored = 1'b1;
      end else begin
        d.action = best_act;
      end
    end else begin
      row_best({r.nother, r.nwait, r.nagent}, best, best_act);
      slot = {r.other, r.waitl, r.agent, r.act};
      // round half up is floor of (x + 1/2)
      target = (longint'(r.rew) * 65536 + longint'(gamma_m) * longint'(best) + 32768) >>> 16;
      mix = (65536 - longint'(alpha_m)) * longint'(q_shadow[slot])
          + longint'(alpha_m) * target;
      qn = (mix + 32768) >>> 16;
      if (qn > Q_MAX) begin
        qn = Q_MAX;
        d.sat = 1'b1;
      end else if (qn < Q_MIN) begin
        qn = Q_MIN;
        d.sat = 1'b1;
      end
      q_shadow[slot] = int'(qn[31:0]);
      d.value = qn[31:0];
      d.action = r.act;
    end
    return d;
  endfunction

  // Driver: hold start until taken, then load the next request
  request_t cur_req;
  int       idle_left = 0;
  bit       gap_rolled = 0;

  always @(posedge clk) begin : drive_requests
    logic taken;
    logic start_n;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
      gap_rolled = 0;
    end else begin
      taken = start && !busy;
      start_n = start && !taken;
      if (taken) begin
        decisions_q.insert(decisions_q.size(), choose_or_learn(cur_req));
      end
      if (!start_n) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (requests_q.size() > 0) begin
          if (!gap_rolled && !steady_tail && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 9) - 1;
            gap_rolled = 1;
          end else if (!(requests_q[0].flush_first && decisions_q.size() > 0)) begin
            cur_req = requests_q.pop_front();
            gap_rolled = 0;
            start_n = 1'b1;
            command <= cur_req.cmd;
            agent_cell <= cur_req.agent;
            other_cell <= cur_req.other;
            wait_level <= cur_req.waitl;
            taken_action <= cur_req.act;
            reward <= cur_req.rew;
            next_agent_cell <= cur_req.nagent;
            next_other_cell <= cur_req.nother;
            next_wait_level <= cur_req.nwait;
            random_bits <= cur_req.rnd;
          end
        end
      end
      start <= start_n;
    end
  end

  // Monitor: check each result against the oldest prediction; watchdog on stalls
  int stall_cycles = 0;

  always @(posedge clk) begin : check_results
    decision_t e;
    if (!rst && done == 1'b1) begin
      if (decisions_q.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: action %0d explored %0d q %0d sat %0d",
                   chosen_action, explored, q_value, saturated);
        end
      end else begin
        e = decisions_q.pop_front();
        if (chosen_action !== e.action || explored !== e.explored ||
            q_value !== e.value || saturated !== e.sat) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: action %0d/%0d explored %0d/%0d q %0d/%0d sat %0d/%0d",
                     e.action, chosen_action, e.explored, explored,
                     e.value, q_value, e.sat, saturated);
          end
        end
      end
    end
    if ((start && !busy) || done == 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[tabular_q_learning_engine] ERROR");
        $finish;
      end
    end
  end

  function automatic request_t make_req(logic cmd, logic [5:0] a, logic [5:0] o,
                                        logic [1:0] w, logic [1:0] act,
                                        logic signed [31:0] rew, logic [5:0] na,
                                        logic [5:0] no, logic [1:0] nw, logic [31:0] rnd);
    request_t r;
    r = '{cmd: cmd, agent: a, other: o, waitl: w, act: act, rew: rew, nagent: na,
          nother: no, nwait: nw, rnd: rnd, flush_first: 0};
    return r;
  endfunction

  // Write one register and mirror it
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_EXPLORE_RATE:    epsilon_m = val;
      REG_LEARNING_RATE:   alpha_m = val;
      REG_DISCOUNT_FACTOR: gamma_m = val;
      default: ;
    endcase
  endtask

  task automatic set_rates(input logic [15:0] eps, input logic [15:0] alpha,
                           input logic [15:0] gamma);
    write_reg(REG_EXPLORE_RATE, eps);
    write_reg(REG_LEARNING_RATE, alpha);
    write_reg(REG_DISCOUNT_FACTOR, gamma);
  endtask

  // Wait until nothing is pending, in flight or outstanding on consecutive edges
  task automatic wait_drained();
    int calm;
    calm = 0;
    while (calm < 2) begin
      @(posedge clk);
      if (requests_q.size() == 0 && !start && decisions_q.size() == 0) calm++;
      else calm = 0;
    end
  endtask

  // Mostly revisit a few states so rows fill up; sometimes go anywhere
  task automatic draw_state(output logic [5:0] a, output logic [5:0] o, output logic [1:0] w);
    int k;
    k = $urandom_range(0, POOL_SIZE - 1);
    if ($urandom_range(0, 6) == 0) begin
      a = 6'($urandom_range(0, 63));
      o = 6'($urandom_range(0, 63));
      w = 2'($urandom_range(0, 3));
    end else begin
      a = pool_agent[k];
      o = pool_other[k];
      w = pool_wait[k];
    end
  endtask

  task automatic queue_random(input int n);
    request_t r;
    int i;
    for (i = 0; i < n; i++) begin
      r.cmd = 1'($urandom_range(0, 1));
      draw_state(r.agent, r.other, r.waitl);
      draw_state(r.nagent, r.nother, r.nwait);
      r.act = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0: r.rew = 32'sh7FFFFFFF;
            1: r.rew = 32'sh80000000;
            2: r.rew = 32'sh0;
            default: r.rew = -32'sd1;
          endcase
        end
        1, 2: r.rew = $urandom;
        default: r.rew = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
      r.rnd = $urandom;
      r.flush_first = ($urandom_range(0, 39) == 0);
      add_req(r);
    end
  endtask

  initial begin : stimulus
    int p;
    pool_agent[0] = 6'd0;  pool_other[0] = 6'd0;  pool_wait[0] = 2'd0;
    pool_agent[1] = 6'd63; pool_other[1] = 6'd63; pool_wait[1] = 2'd3;
    for (p = 2; p < POOL_SIZE; p++) begin
      pool_agent[p] = 6'($urandom_range(0, 63));
      pool_other[p] = 6'($urandom_range(0, 63));
      pool_wait[p] = 2'($urandom_range(0, 3));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty table: greedy tie goes to action 0, then an exploring pick and an update
    add_req(make_req(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_req(make_req(CMD_SELECT, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0002));
    add_req(make_req(CMD_UPDATE, 0, 0, 0, 1, 32'sh0001_0000, 63, 63, 3, 0));
    wait_drained();

    set_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(REG_SPARE, 16'hFFFF);

    // Drive one entry near the top, then past it
    add_req(make_req(CMD_UPDATE, 63, 63, 3, 3, 32'sh7FFFFFFF, 63, 63, 3, 0));
    add_req(make_req(CMD_UPDATE, 63, 63, 3, 3, 32'sh7FFFFFFF, 63, 63, 3, 0));
    add_req(make_req(CMD_SELECT, 63, 63, 3, 0, 0, 0, 0, 0, 32'hFFFF_0000));
    add_req(make_req(CMD_SELECT, 63, 63, 3, 0, 0, 0, 0, 0, 32'hFFFE_FFFD));
    // Fill a row with values near the most negative, then push below it
    for (p = 0; p < 4; p++) begin
      add_req(make_req(CMD_UPDATE, 21, 42, 2, p[1:0], 32'sh80000000, 0, 0, 1, 0));
    end
    add_req(make_req(CMD_UPDATE, 21, 42, 2, 2, 32'sh80000000, 21, 42, 2, 0));
    add_req(make_req(CMD_SELECT, 21, 42, 2, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    add_req(make_req(CMD_UPDATE, 63, 63, 3, 2, -32'sd1, 0, 0, 0, 32'hFFFF_FFFF));
    wait_drained();

    // Zero rates: no exploring, no learning
    set_rates(16'h0000, 16'h0000, 16'h0000);
    add_req(make_req(CMD_SELECT, 63, 63, 3, 0, 0, 0, 0, 0, 32'h0000_0000));
    add_req(make_req(CMD_UPDATE, 63, 63, 3, 3, 32'sh7FFFFFFF, 63, 63, 3, 0));
    add_req(make_req(CMD_UPDATE, 0, 0, 0, 1, 32'sh80000000, 21, 42, 2, 0));
    wait_drained();

    // Random phases over several rate settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_rates(EXPLORE_RATE_RST, LEARNING_RATE_RST, DISCOUNT_FACTOR_RST);
        1: set_rates(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_rates(16'h0000, 16'hFFFF, 16'h0000);
        3: set_rates(16'($urandom), 16'($urandom), 16'($urandom));
        4: set_rates(16'h8000, 16'h0001, 16'hFFFF);
        default: begin
          set_rates(16'($urandom), 16'($urandom), 16'($urandom));
          steady_tail = 1;
        end
      endcase
      queue_random(306);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("[tabular_q_learning_engine] OK");
    end else begin
      $display("[tabular_q_learning_engine] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/qle_pkg.sv
hdl/qle_ram.sv
hdl/qle_update.sv
hdl/tabular_q_learning_engine.sv
tb/tb_tabular_q_learning_engine.sv
